FILE: rtl/core/tkr_pkg.sv
// Package for the two-key top-K ranker.
// Holds default sizes, fixed field widths and opcodes; depends on nothing.
package tkr_pkg;

    localparam int CAPACITY_DEF    = 8;
    localparam int SCORE_WIDTH_DEF = 8;
    localparam int TAG_WIDTH_DEF   = 16;

    // Fixed widths of the rank and count fields on the ports
    localparam int RANK_W  = 3;
    localparam int COUNT_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

FILE: rtl/core/tkr_store.sv
// Entry memory of the ranker: one write port, one read port, registered read data.
// Standalone; sized by the parameters handed down from the top level.
module tkr_store #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/tkr_ctrl.sv
// Sequencer of the ranker: walks the table from the bottom, shifting entries down
// until the new entry's slot is found. Depends on tkr_pkg; drives tkr_store.
module tkr_ctrl
    import tkr_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SCORE_WIDTH = SCORE_WIDTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF,
    parameter int IDX_W       = $clog2(CAPACITY),
    parameter int ENT_W       = TAG_WIDTH + 2 * SCORE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   opcode,
    input  logic [TAG_WIDTH-1:0]   entry_tag,
    input  logic [SCORE_WIDTH-1:0] major_score,
    input  logic [SCORE_WIDTH-1:0] minor_score,
    input  logic [RANK_W-1:0]      read_rank,
    output logic                   busy,
    output logic                   done,
    output logic                   kept,
    output logic [RANK_W-1:0]      insert_rank,
    output logic                   evicted_valid,
    output logic [TAG_WIDTH-1:0]   evicted_tag,
    output logic [COUNT_W-1:0]     entry_count,
    output logic                   read_valid,
    output logic [TAG_WIDTH-1:0]   read_tag,
    output logic [SCORE_WIDTH-1:0] read_major,
    output logic [SCORE_WIDTH-1:0] read_minor,
    output logic                   mem_we,
    output logic [IDX_W-1:0]       mem_waddr,
    output logic [ENT_W-1:0]       mem_wdata,
    output logic [IDX_W-1:0]       mem_raddr,
    input  logic [ENT_W-1:0]       mem_rdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RR_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int KEY_W = 2 * SCORE_WIDTH;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_PLACE = 2'd2;
    localparam logic [1:0] ST_RDOUT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       hole_reg, hole_next;
    logic [ENT_W-1:0]       new_reg, new_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   done_reg, done_next;
    logic                   kept_reg, kept_next;
    logic [RANK_W-1:0]      irank_reg, irank_next;
    logic                   evv_reg, evv_next;
    logic [TAG_WIDTH-1:0]   evtag_reg, evtag_next;
    logic                   rv_reg, rv_next;
    logic [TAG_WIDTH-1:0]   rtag_reg, rtag_next;
    logic [SCORE_WIDTH-1:0] rmaj_reg, rmaj_next;
    logic [SCORE_WIDTH-1:0] rmin_reg, rmin_next;

    logic [KEY_W-1:0]     new_key;
    logic [KEY_W-1:0]     held_key;
    logic [TAG_WIDTH-1:0] held_tag;
    logic [TAG_WIDTH-1:0] new_tag;
    logic                 beats;
    logic                 full;
    logic [IDX_W-1:0]     hole_idx;

    assign new_key  = new_reg[KEY_W-1:0];
    assign new_tag  = new_reg[ENT_W-1 -: TAG_WIDTH];
    assign held_key = mem_rdata[KEY_W-1:0];
    assign held_tag = mem_rdata[ENT_W-1 -: TAG_WIDTH];
    // major score sits above minor score, so one compare ranks both keys
    assign beats    = new_key > held_key;
    assign full     = count_reg == CAP_CNT;
    assign hole_idx = IDX_W'(hole_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        hole_next  = hole_reg;
        new_next   = new_reg;
        rd_ok_next = rd_ok_reg;
        done_next  = 1'b0;
        kept_next  = kept_reg;
        irank_next = irank_reg;
        evv_next   = evv_reg;
        evtag_next = evtag_reg;
        rv_next    = rv_reg;
        rtag_next  = rtag_reg;
        rmaj_next  = rmaj_reg;
        rmin_next  = rmin_reg;
        mem_we     = 1'b0;
        mem_waddr  = hole_idx;
        mem_wdata  = new_reg;
        mem_raddr  = IDX_W'(hole_reg - CNT_W'(1));

        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = IDX_W'(count_reg - CNT_W'(1));
                if (start)
                begin
                    new_next   = {entry_tag, major_score, minor_score};
                    hole_next  = count_reg;
                    kept_next  = 1'b0;
                    irank_next = '0;
                    evv_next   = 1'b0;
                    evtag_next = '0;
                    rv_next    = 1'b0;
                    rtag_next  = '0;
                    rmaj_next  = '0;
                    rmin_next  = '0;
                    if (opcode == OP_READ)
                    begin
                        mem_raddr  = IDX_W'(read_rank);
                        rd_ok_next = RR_W'(read_rank) < RR_W'(count_reg);
                        state_next = ST_RDOUT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end

            ST_CMP:
            begin
                mem_raddr = IDX_W'(hole_reg - CNT_W'(2));
                if (beats)
                begin
                    // shift the held entry down one rank, or drop it past the end
                    if (hole_reg < CAP_CNT)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata;
                    end
                    else
                    begin
                        evv_next   = 1'b1;
                        evtag_next = held_tag;
                    end
                    hole_next = hole_reg - CNT_W'(1);
                    if (hole_reg == CNT_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (hole_reg < CAP_CNT)
                    begin
                        mem_we     = 1'b1;
                        kept_next  = 1'b1;
                        irank_next = RANK_W'(hole_reg);
                        if (!full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // new entry ranks last in a full table: drop it
                        evv_next   = 1'b1;
                        evtag_next = new_tag;
                    end
                end
            end

            ST_PLACE:
            begin
                mem_we     = 1'b1;
                kept_next  = 1'b1;
                irank_next = RANK_W'(hole_reg);
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end

            ST_RDOUT:
            begin
                if (rd_ok_reg)
                begin
                    rv_next   = 1'b1;
                    rtag_next = held_tag;
                    rmaj_next = mem_rdata[KEY_W-1 -: SCORE_WIDTH];
                    rmin_next = mem_rdata[SCORE_WIDTH-1:0];
                end
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg  <= hole_next;
        new_reg   <= new_next;
        rd_ok_reg <= rd_ok_next;
        kept_reg  <= kept_next;
        irank_reg <= irank_next;
        evv_reg   <= evv_next;
        evtag_reg <= evtag_next;
        rv_reg    <= rv_next;
        rtag_reg  <= rtag_next;
        rmaj_reg  <= rmaj_next;
        rmin_reg  <= rmin_next;
    end

    assign busy          = state_reg != ST_IDLE;
    assign done          = done_reg;
    assign kept          = kept_reg;
    assign insert_rank   = irank_reg;
    assign evicted_valid = evv_reg;
    assign evicted_tag   = evtag_reg;
    assign entry_count   = COUNT_W'(count_reg);
    assign read_valid    = rv_reg;
    assign read_tag      = rtag_reg;
    assign read_major    = rmaj_reg;
    assign read_minor    = rmin_reg;

endmodule

FILE: rtl/core/top_k_two_key_ranker.sv
// Top level of the two-key top-K ranker: sequencer plus entry memory.
// Depends on tkr_pkg, tkr_ctrl and tkr_store.
//
//  channel   handshake         payload
//  request   start / busy      opcode, entry_tag, major_score, minor_score, read_rank
//  result    done (1 cycle)    kept, insert_rank, evicted_valid, evicted_tag,
//                              entry_count, read_valid, read_tag, read_major, read_minor
//
// A request is taken when start is high and busy is low; done pulses for one cycle
// once the request completes, and busy is already low in that cycle.
// A read passes through the read-out state to done; an insert compares the new entry
// with the held entries one at a time from the last rank upward, shifting each that
// it passes down one rank. The single memory read port sets this one-at-a-time walk.
// Reset clears the entry count; the memory needs no clearing.
module top_k_two_key_ranker
    import tkr_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SCORE_WIDTH = SCORE_WIDTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   opcode,
    input  logic [TAG_WIDTH-1:0]   entry_tag,
    input  logic [SCORE_WIDTH-1:0] major_score,
    input  logic [SCORE_WIDTH-1:0] minor_score,
    input  logic [RANK_W-1:0]      read_rank,
    output logic                   done,
    output logic                   kept,
    output logic [RANK_W-1:0]      insert_rank,
    output logic                   evicted_valid,
    output logic [TAG_WIDTH-1:0]   evicted_tag,
    output logic [COUNT_W-1:0]     entry_count,
    output logic                   read_valid,
    output logic [TAG_WIDTH-1:0]   read_tag,
    output logic [SCORE_WIDTH-1:0] read_major,
    output logic [SCORE_WIDTH-1:0] read_minor
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = TAG_WIDTH + 2 * SCORE_WIDTH;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    tkr_ctrl #(
        .CAPACITY    (CAPACITY),
        .SCORE_WIDTH (SCORE_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .IDX_W       (IDX_W),
        .ENT_W       (ENT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .entry_tag     (entry_tag),
        .major_score   (major_score),
        .minor_score   (minor_score),
        .read_rank     (read_rank),
        .busy          (busy),
        .done          (done),
        .kept          (kept),
        .insert_rank   (insert_rank),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag),
        .entry_count   (entry_count),
        .read_valid    (read_valid),
        .read_tag      (read_tag),
        .read_major    (read_major),
        .read_minor    (read_minor),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    tkr_store #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

FILE: rtl/core/tkr_checker.sv
// Port-level checks for the two-key top-K ranker, bound to the top level.
// Depends on tkr_pkg and top_k_two_key_ranker.
module tkr_checker
    import tkr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic kept,
    input logic evicted_valid,
    input logic read_valid
);

    // every accepted request occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // the block frees up exactly when a result comes out
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result strobe outside the end of a request");

    // a read result carries no insert outcome
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && read_valid |-> !kept && !evicted_valid)
        else $error("read result mixed with insert fields");

endmodule

bind top_k_two_key_ranker tkr_checker u_tkr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .kept          (kept),
    .evicted_valid (evicted_valid),
    .read_valid    (read_valid)
);

FILE: verif/top_k_two_key_ranker_tb.sv
// Testbench for the two-key top-K ranker: directed and random requests, checked
// against a local ranking table. Depends on tkr_pkg and top_k_two_key_ranker.
module top_k_two_key_ranker_tb;
    import tkr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = CAPACITY_DEF;
    localparam int SW           = SCORE_WIDTH_DEF;
    localparam int TW           = TAG_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1830;
    localparam int MAX_GAP      = 17;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [TW-1:0] tag;
        logic [SW-1:0] major;
        logic [SW-1:0] minor;
    } ranked_entry_t;

    typedef struct {
        logic               kept;
        logic [RANK_W-1:0]  insert_rank;
        logic               evicted_valid;
        logic [TW-1:0]      evicted_tag;
        logic [COUNT_W-1:0] entry_count;
        logic               read_valid;
        logic [TW-1:0]      read_tag;
        logic [SW-1:0]      read_major;
        logic [SW-1:0]      read_minor;
    } rank_outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               opcode = OP_INSERT;
    logic [TW-1:0]      entry_tag = '0;
    logic [SW-1:0]      major_score = '0;
    logic [SW-1:0]      minor_score = '0;
    logic [RANK_W-1:0]  read_rank = '0;
    logic               done;
    logic               kept;
    logic [RANK_W-1:0]  insert_rank;
    logic               evicted_valid;
    logic [TW-1:0]      evicted_tag;
    logic [COUNT_W-1:0] entry_count;
    logic               read_valid;
    logic [TW-1:0]      read_tag;
    logic [SW-1:0]      read_major;
    logic [SW-1:0]      read_minor;

    ranked_entry_t leaderboard [CAP];
    int            leaderboard_count = 0;
    rank_outcome_t due_outcomes[$];
    int            error_count = 0;
    int            cycle_count = 0;

    top_k_two_key_ranker #(
        .CAPACITY   (CAP),
        .SCORE_WIDTH(SW),
        .TAG_WIDTH  (TW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .entry_tag    (entry_tag),
        .major_score  (major_score),
        .minor_score  (minor_score),
        .read_rank    (read_rank),
        .done         (done),
        .kept         (kept),
        .insert_rank  (insert_rank),
        .evicted_valid(evicted_valid),
        .evicted_tag  (evicted_tag),
        .entry_count  (entry_count),
        .read_valid   (read_valid),
        .read_tag     (read_tag),
        .read_major   (read_major),
        .read_minor   (read_minor)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run did not complete in %0d cycles", $time, CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one request to the local table and return what the block must report.
    function automatic rank_outcome_t rank_outcome(logic op, logic [TW-1:0] tag,
                                                   logic [SW-1:0] maj, logic [SW-1:0] mnr,
                                                   logic [RANK_W-1:0] rank);
        rank_outcome_t res;
        int            pos;
        int            last;
        res = '{default: '0};
        if (op == OP_INSERT)
        begin
            pos = 0;
            // Equal keys do not outrank: the new entry lands after them
            while (pos < leaderboard_count &&
                   !(maj > leaderboard[pos].major ||
                     (maj == leaderboard[pos].major && mnr > leaderboard[pos].minor)))
                pos++;
            if (leaderboard_count == CAP && pos >= CAP)
            begin
                res.evicted_valid = 1'b1;
                res.evicted_tag   = tag;
            end
            else
            begin
                if (leaderboard_count == CAP)
                begin
                    res.evicted_valid = 1'b1;
                    res.evicted_tag   = leaderboard[CAP-1].tag;
                    last = CAP - 1;
                end
                else
                begin
                    last = leaderboard_count;
                    leaderboard_count++;
                end
                for (int k = last; k > pos; k--)
                    leaderboard[k] = leaderboard[k-1];
                leaderboard[pos] = '{tag: tag, major: maj, minor: mnr};
                res.kept        = 1'b1;
                res.insert_rank = pos[RANK_W-1:0];
            end
        end
        else if (rank < leaderboard_count)
        begin
            res.read_valid = 1'b1;
            res.read_tag   = leaderboard[rank].tag;
            res.read_major = leaderboard[rank].major;
            res.read_minor = leaderboard[rank].minor;
        end
        res.entry_count = leaderboard_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Match every done pulse against the oldest outstanding request
    always @(posedge clk)
    begin
        rank_outcome_t want;
        if (rst_n && done)
        begin
            if (due_outcomes.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no request outstanding", $time);
            end
            else
            begin
                want = due_outcomes.pop_front();
                check_field("kept", 32'(want.kept), 32'(kept));
                check_field("insert_rank", 32'(want.insert_rank), 32'(insert_rank));
                check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
                check_field("evicted_tag", 32'(want.evicted_tag), 32'(evicted_tag));
                check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                check_field("read_valid", 32'(want.read_valid), 32'(read_valid));
                check_field("read_tag", 32'(want.read_tag), 32'(read_tag));
                check_field("read_major", 32'(want.read_major), 32'(read_major));
                check_field("read_minor", 32'(want.read_minor), 32'(read_minor));
            end
        end
    end

    // Called right after a rising edge; returns at the edge that takes the request.
    task automatic issue_request(logic op, logic [TW-1:0] tag, logic [SW-1:0] maj,
                                 logic [SW-1:0] mnr, logic [RANK_W-1:0] rank, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        entry_tag   <= tag;
        major_score <= maj;
        minor_score <= mnr;
        read_rank   <= rank;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        due_outcomes.push_back(rank_outcome(op, tag, maj, mnr, rank));
    endtask

    task automatic insert_entry(logic [TW-1:0] tag, logic [SW-1:0] maj, logic [SW-1:0] mnr);
        issue_request(OP_INSERT, tag, maj, mnr, '0, $urandom_range(MAX_GAP, 0));
    endtask

    task automatic read_entry(logic [RANK_W-1:0] rank);
        issue_request(OP_READ, '0, '0, '0, rank, $urandom_range(MAX_GAP, 0));
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (due_outcomes.size() != 0);
    endtask

    task automatic test_empty_reads();
        read_entry('0);
        read_entry(RANK_W'(CAP - 1));
    endtask

    task automatic test_fill_with_ties();
        insert_entry(16'h0000, 8'd5, 8'd5);
        insert_entry(16'hFFFF, 8'd5, 8'd5);     // equal key: after the first
        insert_entry(16'h1234, 8'hFF, 8'hFF);   // new best
        insert_entry(16'hA5A5, 8'd0, 8'd0);     // new worst
        insert_entry(16'h5A5A, 8'd5, 8'd6);
        insert_entry(16'h0F0F, 8'd5, 8'd4);
        read_entry(RANK_W'(CAP - 1));            // beyond the count
        insert_entry(16'hF0F0, 8'hFF, 8'd0);
        insert_entry(16'h8001, 8'd0, 8'hFF);
        for (int r = 0; r < CAP; r++)
            read_entry(r[RANK_W-1:0]);
    endtask

    task automatic test_full_table();
        insert_entry(16'hBEEF, 8'd0, 8'd0);     // ties the worst: dropped itself
        insert_entry(16'h7FFF, 8'hFF, 8'hFF);   // ties the best: lands second
        insert_entry(16'h0001, 8'd128, 8'd128);
        read_entry(RANK_W'(CAP - 1));
        read_entry(3'd1);
    endtask

    task automatic test_random_mix();
        logic [SW-1:0] key_pool [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        logic [SW-1:0] maj;
        logic [SW-1:0] mnr;
        int            gap;
        int            pick;
        bit            steady;
        steady = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 96 == 0)
                steady = ($urandom_range(2, 0) == 0);
            if (n % 400 == 399)
                drain_results();
            gap = steady ? 0 : int'($urandom_range(MAX_GAP, 0));
            if ($urandom_range(99, 0) < 35)
            begin
                issue_request(OP_READ, TW'($urandom_range(16'hFFFF, 0)),
                              SW'($urandom_range(255, 0)), SW'($urandom_range(255, 0)),
                              RANK_W'($urandom_range(CAP - 1, 0)), gap);
            end
            else
            begin
                case ($urandom_range(3, 0))
                    0:
                    begin
                        maj = SW'($urandom_range(255, 0));
                        mnr = SW'($urandom_range(255, 0));
                    end
                    1:
                    begin
                        maj = key_pool[$urandom_range(5, 0)];
                        mnr = key_pool[$urandom_range(5, 0)];
                    end
                    2:
                    begin
                        // Tie with a held key, or land just beside it
                        pick = int'($urandom_range(leaderboard_count - 1, 0));
                        maj  = leaderboard[pick].major;
                        mnr  = SW'(leaderboard[pick].minor + $urandom_range(2, 0) - 1);
                    end
                    default:
                    begin
                        maj = SW'($urandom_range(255, 224));
                        mnr = SW'($urandom_range(255, 0));
                    end
                endcase
                issue_request(OP_INSERT, TW'($urandom_range(16'hFFFF, 0)), maj, mnr,
                              RANK_W'($urandom_range(CAP - 1, 0)), gap);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_reads();
        test_fill_with_ties();
        drain_results();
        test_full_table();
        drain_results();
        test_random_mix();
        drain_results();
        repeat (CAP + 4) @(posedge clk);
        if (error_count == 0 && due_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: top_k_two_key_ranker.f
rtl/core/tkr_pkg.sv
rtl/core/tkr_store.sv
rtl/core/tkr_ctrl.sv
rtl/core/top_k_two_key_ranker.sv
rtl/core/tkr_checker.sv
verif/top_k_two_key_ranker_tb.sv
